// File: sv/mtc_pkg.sv
// Shared constants, register indexes and divider beat types for magnetometer trim compensation.
`timescale 1ns / 1ps
`default_nettype none
package mtc_pkg;

  localparam int unsigned OUT_FRAC_BITS_DEF = 8;

  localparam int unsigned NumW  = 64;
  localparam int unsigned DenW  = 43;
  localparam int unsigned QuotW = 32;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [47:0] CalScalesRst = 48'h4000_4000_4000;

  typedef enum logic [CfgAddrW-1:0] {
    CfgTrimXy      = 3'd0,
    CfgTrimZ       = 3'd1,
    CfgTrimHallRef = 3'd2,
    CfgCalEnable   = 3'd3,
    CfgCalOffsets  = 3'd4,
    CfgCalScales   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [NumW-1:0] u;
    logic [DenW-1:0] d;
    logic            neg;
    logic            inv;
  } quot_req_t;

  typedef struct packed {
    logic [QuotW-1:0] q;
    logic             neg;
    logic             inv;
  } quot_t;

endpackage
`default_nettype wire

// File: sv/magnetometer_trim_compensation.sv
// Top level: trim registers, stall control, front end, three dividers and calibration.
//
//  group      dir  handshake           payload
//  s_axis     in   tvalid/tready       tdata[63:0]: eight sensor burst bytes
//  m_axis     out  tvalid/tready       tdata[71:0]: fields x,y,z; tuser[2:0]: invalid flags
//  cfg        in   cfg_we_i            cfg_addr_i, cfg_wdata_i
//
//  One burst accepted per cycle unless the output stalls. Stages: 9 front, 33 divider (a load
//  stage, then one quotient bit each), 5 calibration, the last being the output register.
//  Reset clears valid bits and loads trim/calibration registers with their defaults.
//  All stages advance together while the output register is empty or being taken.
`timescale 1ns / 1ps
`default_nettype none
module magnetometer_trim_compensation #(
  parameter int unsigned OutFracBits = mtc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // x_low, x_high, y_low, y_high, z_low, z_high, hall_low, hall_high
  input  logic [63:0]                   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // field_x, field_y, field_z
  output logic [71:0]                   m_axis_tdata_o,
  // x_invalid, y_invalid, z_invalid
  output logic [2:0]                    m_axis_tuser_o,
  input  logic                          cfg_we_i,
  input  logic [mtc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [mtc_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import mtc_pkg::*;

  logic [47:0] trim_xy_q;
  logic [63:0] trim_z_q;
  logic [15:0] trim_hall_ref_q;
  logic        cal_enable_q;
  logic [59:0] cal_offsets_q;
  logic [47:0] cal_scales_q;

  logic      en;
  logic      fr_vld;
  quot_req_t rq_x, rq_y, rq_z;
  logic      dv_vld_x, dv_vld_y, dv_vld_z;
  quot_t     qt_x, qt_y, qt_z;
  logic      out_vld_x, out_vld_y, out_vld_z;
  logic signed [23:0] fx, fy, fz;
  logic      ix, iy, iz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_xy_q       <= '0;
      trim_z_q        <= '0;
      trim_hall_ref_q <= '0;
      cal_enable_q    <= 1'b0;
      cal_offsets_q   <= '0;
      cal_scales_q    <= CalScalesRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgTrimXy:      trim_xy_q       <= cfg_wdata_i[47:0];
        CfgTrimZ:       trim_z_q        <= cfg_wdata_i;
        CfgTrimHallRef: trim_hall_ref_q <= cfg_wdata_i[15:0];
        CfgCalEnable:   cal_enable_q    <= cfg_wdata_i[0];
        CfgCalOffsets:  cal_offsets_q   <= cfg_wdata_i[59:0];
        CfgCalScales:   cal_scales_q    <= cfg_wdata_i[47:0];
        default: ;
      endcase
    end
  end

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  mtc_front #(.OutFracBits(OutFracBits)) u_front (
    .clk_i,
    .rst_ni,
    .en_i            (en),
    .valid_i         (s_axis_tvalid_i),
    .data_i          (s_axis_tdata_i),
    .trim_xy_i       (trim_xy_q),
    .trim_z_i        (trim_z_q),
    .trim_hall_ref_i (trim_hall_ref_q),
    .valid_o         (fr_vld),
    .req_x_o         (rq_x),
    .req_y_o         (rq_y),
    .req_z_o         (rq_z)
  );

  mtc_div u_div_x (.clk_i, .rst_ni, .en_i(en), .valid_i(fr_vld), .req_i(rq_x),
                   .valid_o(dv_vld_x), .res_o(qt_x));
  mtc_div u_div_y (.clk_i, .rst_ni, .en_i(en), .valid_i(fr_vld), .req_i(rq_y),
                   .valid_o(dv_vld_y), .res_o(qt_y));
  mtc_div u_div_z (.clk_i, .rst_ni, .en_i(en), .valid_i(fr_vld), .req_i(rq_z),
                   .valid_o(dv_vld_z), .res_o(qt_z));

  mtc_cal #(.OutFracBits(OutFracBits)) u_cal_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv_vld_x), .res_i(qt_x),
    .cal_en_i(cal_enable_q), .off_i(cal_offsets_q[19:0]), .scale_i(cal_scales_q[15:0]),
    .valid_o(out_vld_x), .field_o(fx), .inv_o(ix)
  );
  mtc_cal #(.OutFracBits(OutFracBits)) u_cal_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv_vld_y), .res_i(qt_y),
    .cal_en_i(cal_enable_q), .off_i(cal_offsets_q[39:20]), .scale_i(cal_scales_q[31:16]),
    .valid_o(out_vld_y), .field_o(fy), .inv_o(iy)
  );
  mtc_cal #(.OutFracBits(OutFracBits)) u_cal_z (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv_vld_z), .res_i(qt_z),
    .cal_en_i(cal_enable_q), .off_i(cal_offsets_q[59:40]), .scale_i(cal_scales_q[47:32]),
    .valid_o(out_vld_z), .field_o(fz), .inv_o(iz)
  );

  assign m_axis_tvalid_o = out_vld_x;
  assign m_axis_tdata_o  = {fz, fy, fx};
  assign m_axis_tuser_o  = {iz, iy, ix};

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_x == out_vld_y) && (out_vld_x == out_vld_z))
    else $error("axis lanes out of step");

  a_x_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[23:0] == '0)
    else $error("flagged x carries a value");

  a_z_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> m_axis_tdata_o[71:48] == '0)
    else $error("flagged z carries a value");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_vld && !en |=> fr_vld)
    else $error("front beat dropped while stalled");

endmodule
`default_nettype wire

// File: sv/mtc_front.sv
// Unpack, trim products and dividend/divisor build for all three axes.
`timescale 1ns / 1ps
`default_nettype none
module mtc_front #(
  parameter int unsigned OutFracBits = mtc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       data_i,
  input  logic [47:0]       trim_xy_i,
  input  logic [63:0]       trim_z_i,
  input  logic [15:0]       trim_hall_ref_i,
  output logic              valid_o,
  output mtc_pkg::quot_req_t req_x_o,
  output mtc_pkg::quot_req_t req_y_o,
  output mtc_pkg::quot_req_t req_z_o
);
  import mtc_pkg::*;

  typedef struct packed {
    logic signed [12:0] mx;
    logic signed [12:0] my;
    logic signed [14:0] mz;
    logic [13:0]        h;
    logic signed [17:0] d;
    logic               inv_x;
    logic               inv_y;
    logic               inv_z;
  } s0_t;

  typedef struct packed {
    logic signed [12:0] mx;
    logic signed [12:0] my;
    logic [27:0]        hh;
    logic signed [32:0] dh;
    logic signed [35:0] dd;
    logic [29:0]        z1h;
    logic signed [33:0] z3d;
    logic signed [16:0] mz4;
    logic               inv_x;
    logic               inv_y;
    logic               inv_z;
  } s1_t;

  typedef struct packed {
    logic signed [12:0] mx;
    logic signed [12:0] my;
    logic [27:0]        hh;
    logic signed [43:0] t1;
    logic signed [41:0] t2;
    logic signed [36:0] kxh;
    logic signed [36:0] kyh;
    logic signed [33:0] dz;
    logic signed [35:0] nz;
    logic               inv_x;
    logic               inv_y;
    logic               inv_z;
  } s2_t;

  typedef struct packed {
    logic signed [12:0] mx;
    logic signed [12:0] my;
    logic signed [43:0] num;
    logic [DenW-1:0]    den;
    logic signed [36:0] kxh;
    logic signed [36:0] kyh;
    logic signed [33:0] dz;
    logic signed [35:0] nz;
    logic               inv_x;
    logic               inv_y;
    logic               inv_z;
  } s3_t;

  typedef struct packed {
    logic signed [12:0] mx;
    logic signed [12:0] my;
    logic signed [53:0] px;
    logic signed [53:0] py;
    logic [DenW-1:0]    den;
    logic signed [36:0] kxh;
    logic signed [36:0] kyh;
    logic signed [33:0] dz;
    logic signed [35:0] nz;
    logic               inv_x;
    logic               inv_y;
    logic               inv_z;
  } s4_t;

  typedef struct packed {
    logic signed [63:0] mxp;
    logic signed [63:0] myp;
    logic [DenW-1:0]    den;
    logic signed [36:0] kxh;
    logic signed [36:0] kyh;
    logic signed [33:0] dz;
    logic signed [35:0] nz;
    logic               inv_x;
    logic               inv_y;
    logic               inv_z;
  } s5_t;

  typedef struct packed {
    logic signed [63:0] nx;
    logic signed [63:0] ny;
    logic [DenW-1:0]    den;
    logic signed [33:0] dz;
    logic signed [35:0] nz;
    logic               inv_x;
    logic               inv_y;
    logic               inv_z;
  } s6_t;

  typedef struct packed {
    logic [63:0]     ax;
    logic [63:0]     ay;
    logic            sx;
    logic            sy;
    logic [DenW-1:0] den;
    logic [35:0]     anz;
    logic [33:0]     adz;
    logic            sz;
    logic            inv_x;
    logic            inv_y;
    logic            inv_z;
  } s7_t;

  localparam int unsigned Stages = 9;

  logic [Stages-1:0] vld_q;

  s0_t s0_d, s0_q;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;
  s7_t s7_d, s7_q;
  quot_req_t rx_d, rx_q, ry_d, ry_q, rz_d, rz_q;

  logic signed [7:0]  x1, y1, x2, y2, xy2;
  logic [7:0]         xy1;
  logic [15:0]        z1;
  logic signed [15:0] z2, z3, z4;
  logic signed [9:0]  kx2, ky2;

  assign x1  = trim_xy_i[7:0];
  assign y1  = trim_xy_i[15:8];
  assign x2  = trim_xy_i[23:16];
  assign y2  = trim_xy_i[31:24];
  assign xy1 = trim_xy_i[39:32];
  assign xy2 = trim_xy_i[47:40];
  assign z1  = trim_z_i[15:0];
  assign z2  = trim_z_i[31:16];
  assign z3  = trim_z_i[47:32];
  assign z4  = trim_z_i[63:48];
  assign kx2 = 10'(x2) + 10'sd160;
  assign ky2 = 10'(y2) + 10'sd160;

  always_comb begin
    s0_d.mx    = {data_i[15:8], data_i[7:3]};
    s0_d.my    = {data_i[31:24], data_i[23:19]};
    s0_d.mz    = {data_i[47:40], data_i[39:33]};
    s0_d.h     = {data_i[63:56], data_i[55:50]};
    s0_d.d     = $signed({2'b00, trim_hall_ref_i}) - $signed({4'b0000, s0_d.h});
    s0_d.inv_x = (s0_d.mx == 13'sh1000) || (s0_d.h == '0);
    s0_d.inv_y = (s0_d.my == 13'sh1000) || (s0_d.h == '0);
    s0_d.inv_z = (s0_d.mz == 15'sh4000) || (s0_d.h == '0) || (z1 == '0) ||
                 (z2 == '0) || (trim_hall_ref_i == '0);
  end

  always_comb begin
    s1_d.mx    = s0_q.mx;
    s1_d.my    = s0_q.my;
    s1_d.hh    = 28'(s0_q.h) * 28'(s0_q.h);
    s1_d.dh    = 33'(s0_q.d) * 33'($signed({1'b0, s0_q.h}));
    s1_d.dd    = 36'(s0_q.d) * 36'(s0_q.d);
    s1_d.z1h   = 30'(z1) * 30'(s0_q.h);
    s1_d.z3d   = 34'(z3) * 34'(s0_q.d);
    s1_d.mz4   = 17'(s0_q.mz) - 17'(z4);
    s1_d.inv_x = s0_q.inv_x;
    s1_d.inv_y = s0_q.inv_y;
    s1_d.inv_z = s0_q.inv_z;
  end

  always_comb begin
    s2_d.mx    = s1_q.mx;
    s2_d.my    = s1_q.my;
    s2_d.hh    = s1_q.hh;
    s2_d.t1    = 44'(xy2) * 44'(s1_q.dd);
    s2_d.t2    = 42'($signed({1'b0, xy1})) * 42'(s1_q.dh);
    s2_d.kxh   = 37'(x1) * 37'($signed({1'b0, s1_q.hh}));
    s2_d.kyh   = 37'(y1) * 37'($signed({1'b0, s1_q.hh}));
    s2_d.dz    = (34'(z2) <<< 15) + 34'($signed({1'b0, s1_q.z1h}));
    s2_d.nz    = (36'(s1_q.mz4) <<< 17) + 36'(s1_q.z3d);
    s2_d.inv_x = s1_q.inv_x;
    s2_d.inv_y = s1_q.inv_y;
    s2_d.inv_z = s1_q.inv_z;
  end

  always_comb begin
    s3_d.mx    = s2_q.mx;
    s3_d.my    = s2_q.my;
    s3_d.num   = s2_q.t1 + 44'(s2_q.t2) + 44'($signed({1'b0, s2_q.hh, 8'h00}));
    s3_d.den   = DenW'(s2_q.hh) << (17 - OutFracBits);
    s3_d.kxh   = s2_q.kxh;
    s3_d.kyh   = s2_q.kyh;
    s3_d.dz    = s2_q.dz;
    s3_d.nz    = s2_q.nz;
    s3_d.inv_x = s2_q.inv_x;
    s3_d.inv_y = s2_q.inv_y;
    s3_d.inv_z = s2_q.inv_z || (s2_q.dz == '0);
  end

  always_comb begin
    s4_d.mx    = s3_q.mx;
    s4_d.my    = s3_q.my;
    s4_d.px    = 54'(s3_q.num) * 54'(kx2);
    s4_d.py    = 54'(s3_q.num) * 54'(ky2);
    s4_d.den   = s3_q.den;
    s4_d.kxh   = s3_q.kxh;
    s4_d.kyh   = s3_q.kyh;
    s4_d.dz    = s3_q.dz;
    s4_d.nz    = s3_q.nz;
    s4_d.inv_x = s3_q.inv_x;
    s4_d.inv_y = s3_q.inv_y;
    s4_d.inv_z = s3_q.inv_z;
  end

  always_comb begin
    s5_d.mxp   = 64'(s4_q.mx) * 64'(s4_q.px);
    s5_d.myp   = 64'(s4_q.my) * 64'(s4_q.py);
    s5_d.den   = s4_q.den;
    s5_d.kxh   = s4_q.kxh;
    s5_d.kyh   = s4_q.kyh;
    s5_d.dz    = s4_q.dz;
    s5_d.nz    = s4_q.nz;
    s5_d.inv_x = s4_q.inv_x;
    s5_d.inv_y = s4_q.inv_y;
    s5_d.inv_z = s4_q.inv_z;
  end

  always_comb begin
    s6_d.nx    = s5_q.mxp + (64'(s5_q.kxh) <<< 16);
    s6_d.ny    = s5_q.myp + (64'(s5_q.kyh) <<< 16);
    s6_d.den   = s5_q.den;
    s6_d.dz    = s5_q.dz;
    s6_d.nz    = s5_q.nz;
    s6_d.inv_x = s5_q.inv_x;
    s6_d.inv_y = s5_q.inv_y;
    s6_d.inv_z = s5_q.inv_z;
  end

  always_comb begin
    s7_d.ax    = s6_q.nx[63] ? 64'(-s6_q.nx) : 64'(s6_q.nx);
    s7_d.ay    = s6_q.ny[63] ? 64'(-s6_q.ny) : 64'(s6_q.ny);
    s7_d.sx    = s6_q.nx[63];
    s7_d.sy    = s6_q.ny[63];
    s7_d.den   = s6_q.den;
    s7_d.anz   = s6_q.nz[35] ? 36'(-s6_q.nz) : 36'(s6_q.nz);
    s7_d.adz   = s6_q.dz[33] ? 34'(-s6_q.dz) : 34'(s6_q.dz);
    s7_d.sz    = s6_q.nz[35] ^ s6_q.dz[33];
    s7_d.inv_x = s6_q.inv_x;
    s7_d.inv_y = s6_q.inv_y;
    s7_d.inv_z = s6_q.inv_z;
  end

  always_comb begin
    rx_d.u   = (s7_q.ax << 1) + NumW'(s7_q.den);
    rx_d.d   = s7_q.den << 1;
    rx_d.neg = s7_q.sx;
    rx_d.inv = s7_q.inv_x;
    ry_d.u   = (s7_q.ay << 1) + NumW'(s7_q.den);
    ry_d.d   = s7_q.den << 1;
    ry_d.neg = s7_q.sy;
    ry_d.inv = s7_q.inv_y;
    rz_d.u   = (NumW'(s7_q.anz) << (10 + OutFracBits)) + NumW'(s7_q.adz);
    rz_d.d   = DenW'(s7_q.adz) << 1;
    rz_d.neg = s7_q.sz;
    rz_d.inv = s7_q.inv_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
      s7_q <= s7_d;
      rx_q <= rx_d;
      ry_q <= ry_d;
      rz_q <= rz_d;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign req_x_o = rx_q;
  assign req_y_o = ry_q;
  assign req_z_o = rz_q;

endmodule
`default_nettype wire

// File: sv/mtc_div.sv
// Pipelined restoring divider: a load stage, then one quotient bit per stage; saturating quotient.
`timescale 1ns / 1ps
`default_nettype none
module mtc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  mtc_pkg::quot_req_t req_i,
  output logic               valid_o,
  output mtc_pkg::quot_t     res_o
);
  import mtc_pkg::*;

  localparam int unsigned Steps = QuotW;
  localparam int unsigned HiW   = NumW - QuotW;

  logic             vld_q [Steps+1];
  logic [DenW-1:0]  r_q   [Steps+1];
  logic [DenW-1:0]  dv_q  [Steps+1];
  logic [QuotW-1:0] lo_q  [Steps+1];
  logic [QuotW-1:0] qt_q  [Steps+1];
  logic             sat_q [Steps+1];
  logic             neg_q [Steps+1];
  logic             inv_q [Steps+1];

  logic [HiW-1:0] hi;
  logic           sat_d;

  assign hi    = req_i.u[NumW-1:QuotW];
  assign sat_d = {{DenW{1'b0}}, hi} >= {{HiW{1'b0}}, req_i.d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= DenW'(hi);
      dv_q[0]  <= req_i.d;
      lo_q[0]  <= req_i.u[QuotW-1:0];
      qt_q[0]  <= '0;
      sat_q[0] <= sat_d;
      neg_q[0] <= req_i.neg;
      inv_q[0] <= req_i.inv;
    end
  end

  for (genvar k = 1; k <= Steps; k++) begin : g_step
    logic [DenW:0]   r2;
    logic            ge;
    logic [DenW-1:0] rn;

    always_comb begin
      r2 = {r_q[k-1], lo_q[k-1][QuotW-1]};
      ge = r2 >= {1'b0, dv_q[k-1]};
      rn = ge ? DenW'(r2 - {1'b0, dv_q[k-1]}) : r2[DenW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= rn;
        dv_q[k]  <= dv_q[k-1];
        lo_q[k]  <= lo_q[k-1] << 1;
        qt_q[k]  <= {qt_q[k-1][QuotW-2:0], ge};
        sat_q[k] <= sat_q[k-1];
        neg_q[k] <= neg_q[k-1];
        inv_q[k] <= inv_q[k-1];
      end
    end
  end

  assign valid_o   = vld_q[Steps];
  assign res_o.q   = qt_q[Steps] | {QuotW{sat_q[Steps]}};
  assign res_o.neg = neg_q[Steps];
  assign res_o.inv = inv_q[Steps];

endmodule
`default_nettype wire

// File: sv/mtc_cal.sv
// Per-axis signed clamp, then, when enabled, offset and scale calibration with rounding; output saturation.
`timescale 1ns / 1ps
`default_nettype none
module mtc_cal #(
  parameter int unsigned OutFracBits = mtc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mtc_pkg::quot_t      res_i,
  input  logic                cal_en_i,
  input  logic signed [19:0]  off_i,
  input  logic [15:0]         scale_i,
  output logic                valid_o,
  output logic signed [23:0]  field_o,
  output logic                inv_o
);
  import mtc_pkg::*;

  localparam int unsigned Stages = 5;

  logic [Stages-1:0] vld_q;

  logic signed [31:0] v0_d, v0_q, v1_q, v2_q, v3_q;
  logic               i0_q, i1_q, i2_q, i3_q;
  logic signed [33:0] w_d, w_q;
  logic signed [50:0] p_d, p_q;
  logic [50:0]        ap_d, ap_q;
  logic               sp_q;
  logic [36:0]        rq;
  logic signed [37:0] rv, src;
  logic signed [23:0] field_d, field_q;
  logic               inv_q;

  always_comb begin
    if (res_i.neg) begin
      v0_d = (res_i.q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-res_i.q);
    end else begin
      v0_d = (res_i.q > 32'h7fff_ffff) ? 32'sh7fff_ffff : $signed(res_i.q);
    end
  end

  assign w_d  = 34'(v0_q) - (34'(off_i) <<< (OutFracBits - 4));
  assign p_d  = 51'(w_q) * 51'($signed({1'b0, scale_i}));
  assign ap_d = p_q[50] ? 51'(-p_q) : 51'(p_q);

  always_comb begin
    rq  = 37'((ap_q + 51'd8192) >> 14);
    rv  = sp_q ? -38'($signed({1'b0, rq})) : 38'($signed({1'b0, rq}));
    src = cal_en_i ? rv : 38'(v3_q);
    if (i3_q) begin
      field_d = '0;
    end else if (src > 38'sd8388607) begin
      field_d = 24'sh7fffff;
    end else if (src < -38'sd8388608) begin
      field_d = 24'sh800000;
    end else begin
      field_d = src[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v0_q    <= v0_d;
      i0_q    <= res_i.inv;
      v1_q    <= v0_q;
      i1_q    <= i0_q;
      w_q     <= w_d;
      v2_q    <= v1_q;
      i2_q    <= i1_q;
      p_q     <= p_d;
      v3_q    <= v2_q;
      i3_q    <= i2_q;
      ap_q    <= ap_d;
      sp_q    <= p_q[50];
      field_q <= field_d;
      inv_q   <= i3_q;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign field_o = field_q;
  assign inv_o   = inv_q;

endmodule
`default_nettype wire
